[src/esbd_pkg.sv]
// ----------------------------------------------------------------------------
// esbd_pkg: shared types and constants for the escape sequence byte decoder
// Holds the decoder modes, character codes and the burst record that moves
// from the front end through the queue to the output serialiser.
// ----------------------------------------------------------------------------
`default_nettype none

package esbd_pkg;

    // Most bytes that one input byte can cause
    localparam int MaxOut = 6;
    localparam int CountW = $clog2(MaxOut + 1);

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_BSLASH  = 2'd1,
        MODE_DOLLAR  = 2'd2,
        MODE_PERCENT = 2'd3
    } mode_t;

    localparam logic [7:0] CHAR_BSLASH  = 8'h5C;
    localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_LOW_B   = 8'h62;
    localparam logic [7:0] CHAR_LOW_R   = 8'h72;
    localparam logic [7:0] CHAR_LOW_N   = 8'h6E;
    localparam logic [7:0] CHAR_LOW_T   = 8'h74;
    localparam logic [7:0] CHAR_BS      = 8'h08;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_NUL     = 8'h00;

    // Decoded bytes caused by one input byte, in output order
    typedef struct packed {
        logic [CountW-1:0]     count;
        logic [MaxOut-1:0][7:0] data;
    } burst_t;

    // Write side of the queue
    typedef struct packed {
        logic   push;
        burst_t burst;
    } qwr_t;

    // Read side of the queue
    typedef struct packed {
        logic   empty;
        burst_t head;
    } qrd_t;

endpackage

`default_nettype wire

[src/escape_sequence_byte_decoder.sv]
// ----------------------------------------------------------------------------
// escape_sequence_byte_decoder: escape decoding of message bytes
// Turns backslash, dollar-hex and percent-JIS escapes into output bytes.
//
// Input channel: in_valid/in_stall with char_byte, arg_end, message_end; one
// byte is taken per transfer; a new byte may follow each cycle unless stalled.
// Output channel: out_valid/out_stall with out_byte and last_out; last_out
// marks the final byte caused by one input byte. An input byte can cause
// none up to six output bytes (codes, flushes and the CR LF pair).
// The first output byte of an input is registered in the queue and then in the
// serialiser's burst register before it is offered. Throughput: one input
// byte per cycle while the queue is not full and one output byte per cycle
// while out_stall is low; the QUEUE_DEPTH-entry burst queue sets how many
// inputs can run ahead before in_stall rises.
// When the receiver stalls, the current byte holds and the queue fills; once
// full, in_stall rises. cfg_we/cfg_data write suppress_newline, which drops
// the CR LF pair at message end; write it only while the block is idle.
// Reset clears the decoder to plain text mode, empties the queue and clears
// suppress_newline.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_sequence_byte_decoder
    import esbd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] char_byte,
    input  wire logic       arg_end,
    input  wire logic       message_end,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            last_out,
    input  wire logic       cfg_we,
    input  wire logic       cfg_data
);

    qwr_t q_wr;
    qrd_t q_rd;
    logic q_full;
    logic q_pop;

    esbd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_byte   (char_byte),
        .arg_end     (arg_end),
        .message_end (message_end),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .q_full      (q_full),
        .q_wr        (q_wr)
    );

    esbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .q_full (q_full),
        .q_pop  (q_pop),
        .q_rd   (q_rd)
    );

    esbd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_rd      (q_rd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last_out  (last_out)
    );

endmodule

`default_nettype wire

[src/esbd_front.sv]
// ----------------------------------------------------------------------------
// esbd_front: input stage and escape decoder
// Takes one byte per cycle while the queue is not full, steps the escape state
// and builds that input's burst of decoded bytes, which it hands to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module esbd_front
    import esbd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] char_byte,
    input  wire logic       arg_end,
    input  wire logic       message_end,
    input  wire logic       cfg_we,
    input  wire logic       cfg_data,
    input  wire logic       q_full,
    output qwr_t            q_wr
);

    localparam int NumCand = 7;

    mode_t       mode_reg, mode_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [15:0] acc_reg, acc_next;
    logic        suppress_reg;
    logic        accept;
    burst_t      burst;

    logic [NumCand-1:0][7:0] cand;
    logic [NumCand-1:0]      cand_en;
    logic [4:0]              hx;
    logic [15:0]             acc_shift;
    logic                    do_normal;
    logic [15:0]             sj_dec;
    logic [15:0]             sj_flush;
    logic [7:0]              bs_map;

    // {is_hex, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    // JIS row/cell to Shift_JIS, zero for codes outside the table
    function automatic logic [15:0] jis_to_sjis(input logic [15:0] jis);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = jis[15:8];
        lo = jis[7:0];
        if (hi < 8'h21 || hi > 8'h7E || lo < 8'h21 || lo > 8'h7E) begin
            return 16'd0;
        end
        if (hi[0]) begin
            lo = lo + 8'h1F;
            if (lo >= 8'h7F) lo = lo + 8'd1;
        end else begin
            lo = lo + 8'h7E;
        end
        hi = ((hi - 8'h21) >> 1) + 8'h81;
        if (hi >= 8'hA0) hi = hi + 8'h40;
        return {hi, lo};
    endfunction

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        cand      = '0;
        cand_en   = '0;
        do_normal = 1'b0;
        hx        = hex_decode(char_byte);
        acc_shift = {acc_reg[11:0], hx[3:0]};
        sj_dec    = 16'd0;
        sj_flush  = 16'd0;

        unique case (char_byte)
            CHAR_LOW_B: bs_map = CHAR_BS;
            CHAR_LOW_R: bs_map = CHAR_CR;
            CHAR_LOW_N: bs_map = CHAR_LF;
            CHAR_LOW_T: bs_map = CHAR_TAB;
            default:    bs_map = char_byte;
        endcase

        unique case (mode_reg)
            MODE_NORMAL:
            begin
                do_normal = 1'b1;
            end
            MODE_BSLASH:
            begin
                cand[0]    = bs_map;
                cand_en[0] = 1'b1;
                mode_next  = MODE_NORMAL;
                cnt_next   = 2'd0;
                acc_next   = 16'd0;
            end
            MODE_DOLLAR:
            begin
                if (hx[4]) begin
                    acc_next = acc_shift;
                    if (cnt_reg != 2'd0) begin
                        cand[0]    = acc_shift[7:0];
                        cand_en[0] = 1'b1;
                        mode_next  = MODE_NORMAL;
                        cnt_next   = 2'd0;
                        acc_next   = 16'd0;
                    end else begin
                        cnt_next = 2'd1;
                    end
                end else begin
                    cand[0]    = acc_reg[7:0];
                    cand_en[0] = 1'b1;
                    mode_next  = MODE_NORMAL;
                    cnt_next   = 2'd0;
                    acc_next   = 16'd0;
                    do_normal  = 1'b1;
                end
            end
            MODE_PERCENT:
            begin
                if (hx[4]) begin
                    acc_next = acc_shift;
                    if (cnt_reg == 2'd3) begin
                        sj_dec     = jis_to_sjis(acc_shift);
                        cand[0]    = sj_dec[15:8];
                        cand[1]    = sj_dec[7:0];
                        cand_en[1:0] = 2'b11;
                        mode_next  = MODE_NORMAL;
                        cnt_next   = 2'd0;
                        acc_next   = 16'd0;
                    end else begin
                        cnt_next = cnt_reg + 2'd1;
                    end
                end else begin
                    sj_dec       = jis_to_sjis(acc_reg);
                    cand[0]      = sj_dec[15:8];
                    cand[1]      = sj_dec[7:0];
                    cand_en[1:0] = 2'b11;
                    mode_next    = MODE_NORMAL;
                    cnt_next     = 2'd0;
                    acc_next     = 16'd0;
                    do_normal    = 1'b1;
                end
            end
            default:
            begin
                do_normal = 1'b1;
            end
        endcase

        // Byte in plain text, or the byte that ended a code early
        if (do_normal) begin
            unique case (char_byte)
                CHAR_BSLASH:
                begin
                    mode_next = MODE_BSLASH;
                end
                CHAR_DOLLAR:
                begin
                    mode_next = MODE_DOLLAR;
                    cnt_next  = 2'd0;
                    acc_next  = 16'd0;
                end
                CHAR_PERCENT:
                begin
                    mode_next = MODE_PERCENT;
                    cnt_next  = 2'd0;
                    acc_next  = 16'd0;
                end
                default:
                begin
                    cand[2]    = char_byte;
                    cand_en[2] = 1'b1;
                end
            endcase
        end

        // Flush whatever escape is still open at the end of the argument or message
        if (arg_end || message_end) begin
            unique case (mode_next)
                MODE_BSLASH:
                begin
                    cand[3]    = CHAR_NUL;
                    cand_en[3] = 1'b1;
                end
                MODE_DOLLAR:
                begin
                    cand[3]    = acc_next[7:0];
                    cand_en[3] = 1'b1;
                end
                MODE_PERCENT:
                begin
                    sj_flush     = jis_to_sjis(acc_next);
                    cand[3]      = sj_flush[15:8];
                    cand[4]      = sj_flush[7:0];
                    cand_en[4:3] = 2'b11;
                end
                default:
                begin
                end
            endcase
            mode_next = MODE_NORMAL;
            cnt_next  = 2'd0;
            acc_next  = 16'd0;
        end

        if (message_end && !suppress_reg) begin
            cand[5]      = CHAR_CR;
            cand[6]      = CHAR_LF;
            cand_en[6:5] = 2'b11;
        end

        // Pack the enabled candidates into consecutive slots
        burst = '0;
        for (int k = 0; k < NumCand; k++) begin
            if (cand_en[k] && (burst.count < CountW'(MaxOut))) begin
                burst.data[burst.count] = cand[k];
                burst.count             = burst.count + CountW'(1);
            end
        end
    end

    assign q_wr.push  = accept && (burst.count != '0);
    assign q_wr.burst = burst;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg     <= MODE_NORMAL;
            cnt_reg      <= 2'd0;
            acc_reg      <= 16'd0;
            suppress_reg <= 1'b0;
        end else begin
            if (accept) begin
                mode_reg <= mode_next;
                cnt_reg  <= cnt_next;
                acc_reg  <= acc_next;
            end
            if (cfg_we) begin
                suppress_reg <= cfg_data;
            end
        end
    end

    a_normal_clean: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_NORMAL |-> cnt_reg == 2'd0 && acc_reg == 16'd0)
        else $error("code state left over in normal mode");

    a_dollar_short: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_DOLLAR |-> cnt_reg <= 2'd1 && acc_reg[15:4] == 12'd0)
        else $error("dollar code holds more than one digit");

endmodule

`default_nettype wire

[src/esbd_queue.sv]
// ----------------------------------------------------------------------------
// esbd_queue: burst queue between decoder and serialiser
// Small register FIFO of burst records; lets the front end keep taking bytes
// while the output side drains a multi-byte burst.
// ----------------------------------------------------------------------------
`default_nettype none

module esbd_queue
    import esbd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire qwr_t q_wr,
    output logic      q_full,
    input  wire logic q_pop,
    output qrd_t      q_rd
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    burst_t            mem_reg [DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign q_full     = (cnt_reg == CntW'(DEPTH));
    assign q_rd.empty = (cnt_reg == '0);
    assign q_rd.head  = mem_reg[rd_ptr_reg];

    assign do_push = q_wr.push;
    assign do_pop  = q_pop;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (do_push && !do_pop) cnt_next = cnt_reg + CntW'(1);
        else if (do_pop && !do_push) cnt_next = cnt_reg - CntW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= q_wr.burst;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(do_push && q_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(do_pop && q_rd.empty))
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CntW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

[src/esbd_back.sv]
// ----------------------------------------------------------------------------
// esbd_back: output serialiser
// Takes one burst at a time from the queue and sends its bytes one per
// transfer, marking the final byte of each burst.
// ----------------------------------------------------------------------------
`default_nettype none

module esbd_back
    import esbd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire qrd_t       q_rd,
    output logic            q_pop,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            last_out
);

    burst_t            cur_reg, cur_next;
    logic              valid_reg, valid_next;
    logic [CountW-1:0] idx_reg, idx_next;
    logic              take;
    logic              at_last;
    logic              done;

    assign out_valid = valid_reg;
    assign out_byte  = cur_reg.data[idx_reg];
    assign at_last   = (idx_reg == cur_reg.count - CountW'(1));
    assign last_out  = at_last;

    assign take  = valid_reg && !out_stall;
    assign done  = !valid_reg || (take && at_last);
    assign q_pop = done && !q_rd.empty;

    always_comb
    begin
        cur_next   = cur_reg;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        priority if (q_pop) begin
            cur_next   = q_rd.head;
            valid_next = 1'b1;
            idx_next   = '0;
        end else if (done) begin
            valid_next = 1'b0;
            idx_next   = '0;
        end else if (take) begin
            idx_next = idx_reg + CountW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Payload only, no reset
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    a_idx_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> cur_reg.count != '0 && idx_reg < cur_reg.count)
        else $error("byte index outside current burst");

    a_advance_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        take && !at_last |=> valid_reg && idx_reg == $past(idx_reg) + CountW'(1))
        else $error("serialiser did not advance after transfer");

endmodule

`default_nettype wire
